// ===== hdl/gpma_pkg.sv =====
// ----------------------------------------------------------------------------
// gpma_pkg: shared types and constants
// Mode codes, status codes and sequencer states for the GF(2) polynomial
// modular arithmetic block and its channel interfaces.
// ----------------------------------------------------------------------------
package gpma_pkg;

  localparam int MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_ADD  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MUL  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SQR  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POW  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RSQ  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SQRT = 3'd5;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_MOD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEG,
    ST_RED_A,
    ST_RED_B,
    ST_MUL,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/gpma_if.sv =====
// ----------------------------------------------------------------------------
// gpma_if: channel interfaces
// Valid/ready channels for operation requests, results and the modulus write.
// ----------------------------------------------------------------------------
interface gpma_in_if #(
  parameter int POLY_BITS = 16,
  parameter int EXP_BITS  = 16
);
  logic                        valid;
  logic                        ready;
  logic [gpma_pkg::MODE_W-1:0] mode;
  logic [POLY_BITS-1:0]        operand_a;
  logic [POLY_BITS-1:0]        operand_b;
  logic [EXP_BITS-1:0]         exponent;

  modport source (output valid, mode, operand_a, operand_b, exponent, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, exponent, output ready);
endinterface

interface gpma_out_if #(
  parameter int POLY_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [POLY_BITS-1:0] remainder;
  logic                 status;

  modport source (output valid, remainder, status, input ready);
  modport sink   (input valid, remainder, status, output ready);
endinterface

interface gpma_cfg_if #(
  parameter int POLY_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [POLY_BITS-1:0] modulus_poly;

  modport source (output valid, modulus_poly, input ready);
  modport sink   (input valid, modulus_poly, output ready);
endinterface

// ===== hdl/gf2_poly_modular_arith.sv =====
// Operation: a zero or unit modulus goes straight to the result; otherwise the block
//   scans for the modulus degree d, reduces both operands and then runs k modular
//   multiplies (0 for add, 1 for multiply/square, up to 2*EXP_BITS for power, the
//   squaring count for repeated square and square root).
// Throughput: one transaction at a time, the next accepted only once the result is taken;
//   one shift-and-add step per cycle. Reset clears the modulus to zero and idles the block.
// ----------------------------------------------------------------------------
// gf2_poly_modular_arith: modular arithmetic on binary polynomials
// Sum, product, square, power, repeated squaring and square root modulo a
// configured polynomial, all built on one bit-serial multiply/reduce step.
// ----------------------------------------------------------------------------
module gf2_poly_modular_arith #(
  parameter int POLY_BITS = 16,
  parameter int EXP_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  gpma_in_if.sink     in_chan,
  gpma_out_if.source  out_chan,
  gpma_cfg_if.sink    cfg_chan
);
  import gpma_pkg::*;

  localparam int IDX_W  = $clog2(POLY_BITS);
  localparam int EIDX_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
  localparam int CNT_W  = (EXP_BITS > IDX_W) ? EXP_BITS : IDX_W;

  localparam logic [POLY_BITS-1:0] POLY_ONE  = POLY_BITS'(1);
  localparam logic [IDX_W-1:0]     IDX_TOP   = IDX_W'(POLY_BITS - 1);
  localparam logic [IDX_W-1:0]     IDX_ONE   = IDX_W'(1);
  localparam logic [EIDX_W-1:0]    EIDX_TOP  = EIDX_W'(EXP_BITS - 1);
  localparam logic [EIDX_W-1:0]    EIDX_ONE  = EIDX_W'(1);
  localparam logic [CNT_W-1:0]     CNT_ONE   = CNT_W'(1);

  state_t               state_r, state_nxt;
  logic [POLY_BITS-1:0] mod_r;
  logic [IDX_W-1:0]     d_r, d_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [POLY_BITS-1:0] a_r, a_nxt;
  logic [POLY_BITS-1:0] b_r, b_nxt;
  logic [EXP_BITS-1:0]  e_r, e_nxt;
  logic [POLY_BITS-1:0] x_r, x_nxt;
  logic [POLY_BITS-1:0] q_r, q_nxt;
  logic [POLY_BITS-1:0] r_r, r_nxt;
  logic [EIDX_W-1:0]    ebit_r, ebit_nxt;
  logic [CNT_W-1:0]     sq_left_r, sq_left_nxt;
  logic                 pow_mul_r, pow_mul_nxt;
  logic                 status_r, status_nxt;

  logic                 in_acc;
  logic                 out_acc;
  logic                 mod_trivial;
  logic                 pow_take_mul;
  logic                 unit_bit;
  logic [POLY_BITS-1:0] unit_q;
  logic [POLY_BITS-1:0] unit_shift;
  logic [POLY_BITS-1:0] unit_out;

  assign in_acc       = in_chan.valid && in_chan.ready;
  assign out_acc      = out_chan.valid && out_chan.ready;
  assign mod_trivial  = (mod_r == '0) || (mod_r == POLY_ONE);
  assign pow_take_mul = !pow_mul_r && e_r[ebit_r];

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign out_chan.valid     = (state_r == ST_DONE);
  assign out_chan.remainder = x_r;
  assign out_chan.status    = status_r;
  assign cfg_chan.ready     = 1'b1;

  // Shared step: r = (r * z mod m) + bit * q
  always_comb begin
    unit_bit = 1'b0;
    unit_q   = '0;
    case (state_r)
      ST_RED_A: begin
        unit_bit = a_r[cnt_r];
        unit_q   = POLY_ONE;
      end
      ST_RED_B: begin
        unit_bit = b_r[cnt_r];
        unit_q   = POLY_ONE;
      end
      ST_MUL: begin
        unit_bit = x_r[cnt_r];
        unit_q   = q_r;
      end
      default: begin
        unit_bit = 1'b0;
        unit_q   = '0;
      end
    endcase
  end

  always_comb begin
    unit_shift = r_r << 1;
    if (unit_shift[d_r]) begin
      unit_shift = unit_shift ^ mod_r;
    end
    unit_out = unit_shift ^ (unit_bit ? unit_q : '0);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = mod_trivial ? ST_DONE : ST_DEG;
        end
      end
      ST_DEG: begin
        if (mod_r[cnt_r]) begin
          state_nxt = ST_RED_A;
        end
      end
      ST_RED_A: begin
        if (cnt_r == '0) begin
          state_nxt = ST_RED_B;
        end
      end
      ST_RED_B: begin
        if (cnt_r == '0) begin
          case (mode_r)
            MODE_MUL, MODE_SQR, MODE_POW: state_nxt = ST_MUL;
            MODE_RSQ:  state_nxt = (e_r == '0) ? ST_DONE : ST_MUL;
            MODE_SQRT: state_nxt = (d_r == IDX_ONE) ? ST_DONE : ST_MUL;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        if (cnt_r == '0) begin
          case (mode_r)
            MODE_POW: begin
              if (!pow_take_mul && ebit_r == '0) begin
                state_nxt = ST_DONE;
              end
            end
            MODE_RSQ, MODE_SQRT: begin
              if (sq_left_r == CNT_ONE) begin
                state_nxt = ST_DONE;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DONE: begin
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    d_nxt       = d_r;
    cnt_nxt     = cnt_r;
    mode_nxt    = mode_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    e_nxt       = e_r;
    x_nxt       = x_r;
    q_nxt       = q_r;
    r_nxt       = r_r;
    ebit_nxt    = ebit_r;
    sq_left_nxt = sq_left_r;
    pow_mul_nxt = pow_mul_r;
    status_nxt  = status_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          mode_nxt   = in_chan.mode;
          a_nxt      = in_chan.operand_a;
          b_nxt      = in_chan.operand_b;
          e_nxt      = in_chan.exponent;
          cnt_nxt    = IDX_TOP;
          r_nxt      = '0;
          x_nxt      = '0;
          status_nxt = (mod_r == '0) ? STATUS_NO_MOD : STATUS_OK;
        end
      end
      ST_DEG: begin
        // scan down for the leading coefficient of the modulus
        if (mod_r[cnt_r]) begin
          d_nxt   = cnt_r;
          cnt_nxt = IDX_TOP;
        end else begin
          cnt_nxt = cnt_r - IDX_ONE;
        end
      end
      ST_RED_A: begin
        r_nxt   = unit_out;
        cnt_nxt = cnt_r - IDX_ONE;
        if (cnt_r == '0) begin
          a_nxt   = unit_out;
          r_nxt   = '0;
          cnt_nxt = IDX_TOP;
        end
      end
      ST_RED_B: begin
        r_nxt   = unit_out;
        cnt_nxt = cnt_r - IDX_ONE;
        if (cnt_r == '0) begin
          b_nxt   = unit_out;
          r_nxt   = '0;
          cnt_nxt = d_r - IDX_ONE;
          case (mode_r)
            MODE_ADD: x_nxt = a_r ^ unit_out;
            MODE_MUL: begin
              x_nxt = a_r;
              q_nxt = unit_out;
            end
            MODE_SQR: begin
              x_nxt = a_r;
              q_nxt = a_r;
            end
            MODE_POW: begin
              x_nxt       = POLY_ONE;
              q_nxt       = POLY_ONE;
              ebit_nxt    = EIDX_TOP;
              pow_mul_nxt = 1'b0;
            end
            MODE_RSQ: begin
              x_nxt       = a_r;
              q_nxt       = a_r;
              sq_left_nxt = CNT_W'(e_r);
            end
            MODE_SQRT: begin
              x_nxt       = a_r;
              q_nxt       = a_r;
              sq_left_nxt = CNT_W'(d_r - IDX_ONE);
            end
            default: x_nxt = '0;
          endcase
        end
      end
      ST_MUL: begin
        r_nxt   = unit_out;
        cnt_nxt = cnt_r - IDX_ONE;
        if (cnt_r == '0) begin
          x_nxt   = unit_out;
          r_nxt   = '0;
          cnt_nxt = d_r - IDX_ONE;
          case (mode_r)
            MODE_POW: begin
              // square first, then multiply by a where the exponent bit is set
              if (pow_take_mul) begin
                q_nxt       = a_r;
                pow_mul_nxt = 1'b1;
              end else begin
                q_nxt       = unit_out;
                pow_mul_nxt = 1'b0;
                ebit_nxt    = ebit_r - EIDX_ONE;
              end
            end
            MODE_RSQ, MODE_SQRT: begin
              q_nxt       = unit_out;
              sq_left_nxt = sq_left_r - CNT_ONE;
            end
            default: q_nxt = q_r;
          endcase
        end
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mod_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        mod_r <= cfg_chan.modulus_poly;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r       <= d_nxt;
    cnt_r     <= cnt_nxt;
    mode_r    <= mode_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    e_r       <= e_nxt;
    x_r       <= x_nxt;
    q_r       <= q_nxt;
    r_r       <= r_nxt;
    ebit_r    <= ebit_nxt;
    sq_left_r <= sq_left_nxt;
    pow_mul_r <= pow_mul_nxt;
    status_r  <= status_nxt;
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: GF(2) polynomial modular arithmetic block
// Drives a directed table, then random phases under several moduli, through
// valid/ready channels with random idling and one long result back-pressure
// stretch. Every result is checked in order against a literal table answer or an
// in-bench model of the arithmetic.
// ----------------------------------------------------------------------------
module testbench;
  import gpma_pkg::*;

  localparam int PB = 16;
  localparam int EB = 16;

  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  localparam int N_DIRECTED    = 25;
  localparam int N_PHASES      = 9;
  localparam int PHASE_ITEMS   = 50;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 100;

  typedef logic [PB-1:0] poly_t;

  typedef struct packed {
    poly_t remainder;
    logic  status;
  } poly_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    poly_t             a;
    poly_t             b;
    logic [EB-1:0]     e;
  } poly_op_t;

  // Directed stimulus: modulus in force, operation, and an optional literal answer
  typedef struct packed {
    poly_t             modulus;
    logic [MODE_W-1:0] mode;
    poly_t             a;
    poly_t             b;
    logic [EB-1:0]     e;
    logic              known;
    poly_t             remainder;
    logic              status;
  } directed_row_t;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{16'h0000, MODE_ADD,     16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, STATUS_NO_MOD},
    '{16'h0000, MODE_SPARE_7, 16'h1234, 16'h5678, 16'hFFFF, 1'b1, 16'h0000, STATUS_NO_MOD},
    '{16'h0001, MODE_MUL,     16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, STATUS_OK},
    '{16'h0001, MODE_POW,     16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, STATUS_OK},
    '{16'h0001, MODE_SQRT,    16'hFFFF, 16'h0000, 16'h0000, 1'b1, 16'h0000, STATUS_OK},
    '{16'h011B, MODE_ADD,     16'h0053, 16'h00CA, 16'h0000, 1'b1, 16'h0099, STATUS_OK},
    '{16'h011B, MODE_MUL,     16'h0053, 16'h00CA, 16'h0000, 1'b1, 16'h0001, STATUS_OK},
    '{16'h011B, MODE_POW,     16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0001, STATUS_OK},
    '{16'h011B, MODE_POW,     16'h0053, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, STATUS_OK},
    '{16'h011B, MODE_RSQ,     16'h0057, 16'h0000, 16'h0000, 1'b1, 16'h0057, STATUS_OK},
    '{16'h011B, MODE_RSQ,     16'h0057, 16'h0000, 16'h0008, 1'b1, 16'h0057, STATUS_OK},
    '{16'h011B, MODE_SQR,     16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 16'h0000, STATUS_OK},
    '{16'h011B, MODE_SQRT,    16'h1234, 16'h0000, 16'h0000, 1'b0, 16'h0000, STATUS_OK},
    '{16'h011B, MODE_SPARE_6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, STATUS_OK},
    '{16'h011B, MODE_SPARE_7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, STATUS_OK},
    '{16'hFFFF, MODE_MUL,     16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 16'h0000, STATUS_OK},
    '{16'hFFFF, MODE_POW,     16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 16'h0000, STATUS_OK},
    '{16'hFFFF, MODE_SQRT,    16'h8000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STATUS_OK},
    '{16'hFFFF, MODE_RSQ,     16'hABCD, 16'h0000, 16'h0014, 1'b0, 16'h0000, STATUS_OK},
    '{16'h8000, MODE_ADD,     16'h8000, 16'h0000, 16'h0000, 1'b1, 16'h0000, STATUS_OK},
    '{16'h8000, MODE_SQR,     16'h4000, 16'h0000, 16'h0000, 1'b0, 16'h0000, STATUS_OK},
    '{16'h0003, MODE_SQRT,    16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, STATUS_OK},
    '{16'h0003, MODE_RSQ,     16'h0001, 16'h0000, 16'hFFFF, 1'b1, 16'h0001, STATUS_OK},
    '{16'h0002, MODE_MUL,     16'h0003, 16'h0003, 16'h0000, 1'b0, 16'h0000, STATUS_OK},
    '{16'h0000, MODE_SQRT,    16'h55AA, 16'h0000, 16'h0000, 1'b1, 16'h0000, STATUS_NO_MOD}
  };

  logic clk;
  logic rst_n;

  gpma_in_if  #(.POLY_BITS(PB), .EXP_BITS(EB)) in_chan  ();
  gpma_out_if #(.POLY_BITS(PB))                out_chan ();
  gpma_cfg_if #(.POLY_BITS(PB))                cfg_chan ();

  gf2_poly_modular_arith #(.POLY_BITS(PB), .EXP_BITS(EB)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  poly_result_t pending_remainders [$];
  poly_t        modulus_now;
  bit           calm;
  bit           held;
  int unsigned  mismatches;
  int unsigned  ops_sent;
  int unsigned  results_seen;
  int unsigned  modulus_writes;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Arithmetic model
  // ---------------------------------------------------------------------------
  function automatic int unsigned poly_degree(poly_t x);
    int unsigned d;
    d = 0;
    for (int i = 0; i < PB; i++)
      if (x[i]) d = i;
    return d;
  endfunction

  function automatic poly_t poly_reduce(poly_t x, poly_t m, int unsigned d);
    for (int i = PB - 1; i >= int'(d); i--)
      if (x[i]) x = x ^ (m << (i - int'(d)));
    return x;
  endfunction

  // Shift and add, top bit first; operands already reduced
  function automatic poly_t poly_mulmod(poly_t a, poly_t b, poly_t m, int unsigned d);
    logic [PB:0] acc;
    acc = '0;
    if (d == 0) return '0;
    for (int i = int'(d) - 1; i >= 0; i--) begin
      acc = acc << 1;
      if (acc[d]) acc = acc ^ {1'b0, m};
      if (a[i]) acc = acc ^ {1'b0, b};
    end
    return acc[PB-1:0];
  endfunction

  function automatic poly_result_t modular_result(poly_op_t op, poly_t m);
    poly_result_t res;
    int unsigned  d;
    int unsigned  count;
    poly_t        a;
    poly_t        b;
    poly_t        r;
    res.remainder = '0;
    res.status    = STATUS_NO_MOD;
    if (m == '0) return res;
    d = poly_degree(m);
    a = poly_reduce(op.a, m, d);
    b = poly_reduce(op.b, m, d);
    r = '0;
    case (op.mode)
      MODE_ADD: r = a ^ b;
      MODE_MUL: r = poly_mulmod(a, b, m, d);
      MODE_SQR: r = poly_mulmod(a, a, m, d);
      MODE_POW: begin
        r = poly_reduce(poly_t'(1), m, d);
        for (int i = EB - 1; i >= 0; i--) begin
          r = poly_mulmod(r, r, m, d);
          if (op.e[i]) r = poly_mulmod(r, a, m, d);
        end
      end
      MODE_RSQ, MODE_SQRT: begin
        if (op.mode == MODE_RSQ) count = op.e;
        else count = (d == 0) ? 0 : d - 1;
        r = a;
        for (int unsigned k = 0; k < count; k++)
          r = poly_mulmod(r, r, m, d);
      end
      default: r = '0;
    endcase
    res.remainder = r;
    res.status    = STATUS_OK;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    poly_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (pending_remainders.size() == 0) begin
        report_mismatch($sformatf("unexpected result remainder=%h status=%b",
                                  out_chan.remainder, out_chan.status));
      end else begin
        want = pending_remainders.pop_front();
        if (out_chan.remainder !== want.remainder)
          report_mismatch($sformatf("result %0d remainder %h, want %h",
                                    results_seen, out_chan.remainder, want.remainder));
        if (out_chan.status !== want.status)
          report_mismatch($sformatf("result %0d status %b, want %b",
                                    results_seen, out_chan.status, want.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random ready bursts, one long hold to back the block up
  // ---------------------------------------------------------------------------
  initial begin
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && !held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_chan.ready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_chan.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_op(poly_op_t op, poly_result_t want);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_chan.mode      = op.mode;
    in_chan.operand_a = op.a;
    in_chan.operand_b = op.b;
    in_chan.exponent  = op.e;
    in_chan.valid     = 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_remainders.push_back(want);
    ops_sent++;
  endtask

  // Drop valid and let every outstanding transaction come back
  task automatic drain_block();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_remainders.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_modulus(poly_t value);
    @(negedge clk);
    cfg_chan.modulus_poly = value;
    cfg_chan.valid        = 1'b1;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    modulus_now = value;
    modulus_writes++;
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  function automatic poly_t pick_poly();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return poly_t'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    poly_op_t     op;
    poly_result_t want;
    poly_t        m;
    int unsigned  d;
    int unsigned  r;

    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.mode          = MODE_ADD;
    in_chan.operand_a     = '0;
    in_chan.operand_b     = '0;
    in_chan.exponent      = '0;
    cfg_chan.valid        = 1'b0;
    cfg_chan.modulus_poly = '0;
    modulus_now           = '0;
    calm                  = 1'b0;
    held                  = 1'b0;
    mismatches            = 0;
    ops_sent              = 0;
    results_seen          = 0;
    modulus_writes        = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].modulus != modulus_now) begin
        drain_block();
        write_modulus(directed_rows[i].modulus);
      end
      op.mode = directed_rows[i].mode;
      op.a    = directed_rows[i].a;
      op.b    = directed_rows[i].b;
      op.e    = directed_rows[i].e;
      if (directed_rows[i].known) begin
        want.remainder = directed_rows[i].remainder;
        want.status    = directed_rows[i].status;
      end else begin
        want = modular_result(op, modulus_now);
      end
      send_op(op, want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_block();
      // Mostly ordinary moduli of every degree, now and then an extreme one
      case (ph == 0 ? 3 : $urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 5))
            0:       m = 16'h0000;
            1:       m = 16'h0001;
            2:       m = 16'h0002;
            3:       m = 16'h0003;
            4:       m = 16'h8000;
            default: m = 16'hFFFF;
          endcase
        end
        1, 2:    m = 16'h8000 | poly_t'($urandom);
        default: begin
          d = $urandom_range(1, PB - 1);
          m = (poly_t'(1) << d) | (poly_t'($urandom) & ((poly_t'(1) << d) - 1));
        end
      endcase
      write_modulus(m);
      if (ph == N_PHASES - 1) calm = 1'b1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 19);
        if (r == 0) op.mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
        else op.mode = MODE_W'((r - 1) % 6);
        op.a = pick_poly();
        op.b = pick_poly();
        // Keep squaring counts short; a long count costs a multiply per step
        if (op.mode == MODE_RSQ)
          op.e = ($urandom_range(0, 24) == 0) ? EB'($urandom_range(0, 600))
                                              : EB'($urandom_range(0, 24));
        else
          op.e = EB'($urandom);
        send_op(op, modular_result(op, modulus_now));
      end
    end

    drain_block();
    repeat (50) @(posedge clk);

    $display("Sent %0d operations over %0d modulus writes, checked %0d results",
             ops_sent, modulus_writes, results_seen);
    $display("Covered all modes, spare codes, zero/unit moduli and a long output stall");
    if (mismatches == 0 && pending_remainders.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #250000000;
    $display("Timeout with %0d results outstanding", pending_remainders.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/gpma_pkg.sv
hdl/gpma_if.sv
hdl/gf2_poly_modular_arith.sv
dv/testbench.sv
